// ----- hdl/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// sha256_pkg: shared types, constants and round functions
// Payload structs, initial hash, round constants and the control/status
// structs between the SHA-256 controller and datapath.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_upper_mid;
    logic [63:0] digest_lower_mid;
    logic [63:0] digest_low;
  } out_item_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned ROUNDS = 64;

  typedef logic [31:0] word_t;

  // byte source for a buffer write
  typedef enum logic [1:0] {
    BSRC_DATA,
    BSRC_PAD,
    BSRC_ZERO,
    BSRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic       wr_byte;     // write one byte into the block buffer
    byte_src_t  src;
    logic [5:0] wr_pos;
    logic       cnt_inc;     // bump message byte count
    logic       cnt_clr;
    logic       blk_start;   // load working vars, start schedule
    logic       round;       // run one round with index rnd
    logic [5:0] rnd;
    logic       fold;        // add working vars into hash
    logic       hash_init;   // reload initial hash
    logic       dig_load;    // copy hash into the digest output register
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] pos;         // message byte count modulo 64
  } dp_stat_t;

  function automatic word_t init_hash(input logic [2:0] i);
    unique case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- hdl/sha256_datapath.sv -----
// ----------------------------------------------------------------------------
// sha256_datapath: block buffer, message schedule and round unit
// Holds the 64-byte block as 16 words, a 16-word schedule shift window, the
// byte count, the running hash, the eight working variables and the digest
// output register; one round per cycle.
// ----------------------------------------------------------------------------
module sha256_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sha256_pkg::dp_cmd_t cmd,
  input  logic [7:0]          data_byte,
  output sha256_pkg::dp_stat_t stat,
  output sha256_pkg::out_item_t digest
);

  logic [60:0]        byte_count;
  sha256_pkg::word_t  blk   [16];   // block words, big-endian
  sha256_pkg::word_t  win   [16];   // schedule window
  sha256_pkg::word_t  hash  [8];
  sha256_pkg::word_t  v     [8];
  sha256_pkg::out_item_t dig;

  logic [7:0]         wr_val;
  logic [63:0]        bit_len;
  sha256_pkg::word_t  w_cur, w_new, s0, s1, big0, big1, ch, maj, t1, t2;

  assign bit_len = {byte_count, 3'b000};

  always_comb begin
    case (cmd.src)
      sha256_pkg::BSRC_DATA: wr_val = data_byte;
      sha256_pkg::BSRC_PAD:  wr_val = sha256_pkg::PAD_BYTE;
      sha256_pkg::BSRC_ZERO: wr_val = 8'h00;
      default:               wr_val = bit_len[(7 - cmd.wr_pos[2:0]) * 8 +: 8];
    endcase
  end

  // schedule: first 16 rounds use the block, later ones extend the window
  always_comb begin
    s0    = sha256_pkg::rotr(win[1], 7) ^ sha256_pkg::rotr(win[1], 18) ^ (win[1] >> 3);
    s1    = sha256_pkg::rotr(win[14], 17) ^ sha256_pkg::rotr(win[14], 19) ^ (win[14] >> 10);
    w_new = s1 + win[9] + s0 + win[0];
    w_cur = (cmd.rnd < 6'd16) ? win[0] : w_new;
    big1  = sha256_pkg::rotr(v[4], 6) ^ sha256_pkg::rotr(v[4], 11) ^ sha256_pkg::rotr(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    big0  = sha256_pkg::rotr(v[0], 2) ^ sha256_pkg::rotr(v[0], 13) ^ sha256_pkg::rotr(v[0], 22);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + big1 + ch + sha256_pkg::K_TAB[cmd.rnd] + w_cur;
    t2    = big0 + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (cmd.cnt_clr) begin
      byte_count <= '0;
    end else if (cmd.cnt_inc) begin
      byte_count <= byte_count + 61'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.hash_init) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::init_hash(3'(i));
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dig_load) begin
      dig <= '{{hash[0], hash[1]}, {hash[2], hash[3]},
               {hash[4], hash[5]}, {hash[6], hash[7]}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      blk[cmd.wr_pos[5:2]][(3 - cmd.wr_pos[1:0]) * 8 +: 8] <= wr_val;
    end
    if (cmd.blk_start) begin
      for (int i = 0; i < 16; i++) win[i] <= blk[i];
      for (int i = 0; i < 8; i++) v[i] <= hash[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= w_cur;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  assign stat.pos = byte_count[5:0];
  assign digest = dig;

endmodule

// ----- hdl/sha256_ctrl.sv -----
// ----------------------------------------------------------------------------
// sha256_ctrl: item handshake and block sequencing
// Takes bytes, fires compressions on full blocks, writes the padding and
// length, and hands out the digest.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_carries,
  input  logic                 in_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  sha256_pkg::dp_stat_t stat,
  output sha256_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ROUND, S_FOLD, S_PAD, S_OUT
  } state_t;

  state_t     state, state_next;
  logic [5:0] rnd, rnd_next;
  logic [5:0] ppos, ppos_next;     // padding write position
  logic       fin, fin_next;        // message end pending after this block
  logic       last, last_next;      // block being compressed is the final one
  logic       pad2, pad2_next;      // length needs a second padding block
  logic       out_valid_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    ppos_next  = ppos;
    fin_next   = fin;
    last_next  = last;
    pad2_next  = pad2;
    out_valid_next = out_valid && out_stall;
    cmd        = '0;
    cmd.rnd    = rnd;
    cmd.wr_pos = stat.pos;
    cmd.src    = sha256_pkg::BSRC_DATA;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          fin_next = in_end;
          if (in_carries) begin
            cmd.wr_byte = 1'b1;
            cmd.cnt_inc = 1'b1;
          end
          if (in_carries && stat.pos == 6'd63) begin
            state_next = S_START;
            last_next  = 1'b0;
          end else if (in_end) begin
            state_next = S_PAD;
            ppos_next  = stat.pos + 6'(in_carries);
          end
        end
      end
      S_START: begin
        cmd.blk_start = 1'b1;
        rnd_next   = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 6'd1;
        if (rnd == 6'(sha256_pkg::ROUNDS - 1)) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (last) begin
          state_next = S_OUT;
        end else if (fin) begin
          state_next = S_PAD;
          ppos_next  = stat.pos;
        end else if (pad2) begin
          // zeros and length only
          state_next = S_PAD;
          ppos_next  = '0;
          pad2_next  = 1'b0;
          last_next  = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PAD: begin
        // the 0x80 marker first if the message ends here, then zeros, then length at 56..63 in the final block
        cmd.wr_byte = 1'b1;
        cmd.wr_pos  = ppos;
        if (ppos == stat.pos && fin) cmd.src = sha256_pkg::BSRC_PAD;
        else if (ppos >= 6'd56 && last) cmd.src = sha256_pkg::BSRC_LEN;
        else cmd.src = sha256_pkg::BSRC_ZERO;
        fin_next  = 1'b0;
        ppos_next = ppos + 6'd1;
        if (ppos == stat.pos && fin) begin
          // marker fits with length only if it lands before byte 56
          last_next = (ppos < 6'd56);
          pad2_next = (ppos >= 6'd56);
        end
        if (ppos == 6'd63) state_next = S_START;
      end
      S_OUT: begin
        // move the digest out once the output register is free
        if (!out_valid || !out_stall) begin
          cmd.dig_load   = 1'b1;
          cmd.hash_init  = 1'b1;
          cmd.cnt_clr    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rnd       <= '0;
      ppos      <= '0;
      fin       <= 1'b0;
      last      <= 1'b0;
      pad2      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      ppos      <= ppos_next;
      fin       <= fin_next;
      last      <= last_next;
      pad2      <= pad2_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_round_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_START |=> state == S_ROUND && rnd == 6'd0)
    else $error("round count not cleared at block start");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> in_stall)
    else $error("busy state not stalling");
  a_out_after_fold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("digest shown without final block");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled digest dropped");
`endif

endmodule

// ----- hdl/sha256_message_hasher_core.sv -----
// ----------------------------------------------------------------------------
// sha256_message_hasher_core: byte-stream SHA-256 hasher
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// At most one byte per item; bytes are taken one a cycle until a 64-byte block
// fills, then input stalls while it is compressed (load, 64 rounds through a single
// round unit, hash add). At end of message the padding is written one byte
// a cycle into the buffer (64 minus the fill position, so up to 64 bytes)
// and one compression follows; when the 0x80 marker lands at
// byte 56 or later a second padding block of 64 bytes and another
// compression are needed. If the end item also fills a block, that block is
// compressed first. The digest then moves to an output register in the S_OUT
// state and input opens again; if the previous digest still waits there,
// input stays stalled until it is taken.
module sha256_message_hasher_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha256_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha256_pkg::out_item_t out_item
);

  sha256_pkg::dp_cmd_t  cmd;
  sha256_pkg::dp_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_carries (in_item.carries_byte),
    .in_end     (in_item.end_of_message),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha256_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (in_item.data_byte),
    .stat      (stat),
    .digest    (out_item)
  );

endmodule
